// ----- hw/rtl/cdbwb_pkg.sv -----
// Package with the shared types and constants of the writeback and wakeup block.
`timescale 1ns / 1ps
package cdbwb_pkg;
  localparam int NumStations = 16;
  localparam int IdxW = 4;
  localparam int ValW = 64;
  localparam int AgeW = 16;
  localparam int TagW = 6;
  localparam int RobW = 5;
  localparam logic [TagW-1:0] NullTag = 6'd32;

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdWriteback = 2'd1,
    CmdRead = 2'd2,
    CmdNop = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StFree = 2'd0,
    StPending = 2'd1,
    StFinished = 2'd2,
    StInvalid = 2'd3
  } status_e;

  localparam logic [1:0] KindValue = 2'd0;

  typedef enum logic [1:0] {
    FsmIdle = 2'd0,
    FsmSelect = 2'd1,
    FsmOut = 2'd2
  } fsm_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic out_taken;
  } ctrl_t;

  typedef struct packed {
    logic dummy;
  } stat_t;
endpackage

// ----- hw/rtl/cdbwb_ctrl.sv -----
// Controller state machine that sequences one transaction through the datapath.
`timescale 1ns / 1ps
module cdbwb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cdbwb_pkg::ctrl_t ctrl_o
);
  cdbwb_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdbwb_pkg::FsmIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    ctrl_o = '0;
    case (state_q)
      cdbwb_pkg::FsmIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = cdbwb_pkg::FsmSelect;
        end
      end
      cdbwb_pkg::FsmSelect: begin
        ctrl_o.exec = 1'b1;
        state_d = cdbwb_pkg::FsmOut;
      end
      cdbwb_pkg::FsmOut: begin
        out_valid_o = 1'b1;
        in_ready_o = out_ready_i;
        if (out_ready_i) begin
          ctrl_o.out_taken = 1'b1;
          if (in_valid_i) begin
            ctrl_o.load = 1'b1;
            state_d = cdbwb_pkg::FsmSelect;
          end else begin
            state_d = cdbwb_pkg::FsmIdle;
          end
        end
      end
      default: state_d = cdbwb_pkg::FsmIdle;
    endcase
  end
endmodule

// ----- hw/rtl/cdbwb_dp.sv -----
// Datapath with the station table, the oldest-finished search and the tag wakeup.
`timescale 1ns / 1ps
module cdbwb_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cdbwb_pkg::ctrl_t ctrl_i,
  input  logic [4:0]       cfg_wdata_i,
  input  logic             cfg_we_i,
  input  logic [235:0]     in_data_i,
  output logic [215:0]     out_data_o
);
  localparam int N = cdbwb_pkg::NumStations;
  localparam int VW = cdbwb_pkg::ValW;
  localparam int AW = cdbwb_pkg::AgeW;
  localparam int TW = cdbwb_pkg::TagW;

  logic [4:0] use_q;
  logic [1:0] status_q [N];
  logic [TW-1:0] wait_a_q [N];
  logic [TW-1:0] wait_b_q [N];
  logic [AW-1:0] age_q [N];
  logic [VW-1:0] res_q [N];
  logic [4:0] rob_q [N];
  logic [1:0] kind_q [N];
  logic cond_q [N];
  logic [VW-1:0] opa_q [N];
  logic [VW-1:0] opb_q [N];

  logic [1:0] cmd_q;
  logic [3:0] idx_q;
  logic [1:0] est_q;
  logic [AW-1:0] eage_q;
  logic [VW-1:0] eres_q;
  logic [4:0] erob_q;
  logic [1:0] ekind_q;
  logic econd_q;
  logic [TW-1:0] ewa_q, ewb_q;
  logic [VW-1:0] eopa_q, eopb_q;
  logic [215:0] out_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= in_data_i[1:0];
      idx_q <= in_data_i[5:2];
      est_q <= in_data_i[7:6];
      eage_q <= in_data_i[23:8];
      eres_q <= in_data_i[87:24];
      erob_q <= in_data_i[92:88];
      ekind_q <= in_data_i[94:93];
      econd_q <= in_data_i[95];
      ewa_q <= in_data_i[101:96];
      ewb_q <= in_data_i[107:102];
      eopa_q <= in_data_i[171:108];
      eopb_q <= in_data_i[235:172];
    end
  end

  // Oldest finished station among those in use, lowest index on a tie.
  // The search is a tree of pairwise compares; the lower half wins ties.
  logic [5:0] lim;
  logic found;
  logic [3:0] win;
  logic t_f [2*N-1];
  logic [3:0] t_i [2*N-1];
  logic [AW-1:0] t_a [2*N-1];

  assign lim = (use_q > 5'd16) ? 6'd16 : {1'b0, use_q};

  always_comb begin
    for (int i = 0; i < N; i++) begin
      t_f[N-1+i] = (6'(i) < lim) && (status_q[i] == cdbwb_pkg::StFinished);
      t_i[N-1+i] = 4'(i);
      t_a[N-1+i] = age_q[i];
    end
    for (int k = N - 2; k >= 0; k--) begin
      if (t_f[2*k+2] && (!t_f[2*k+1] || (t_a[2*k+2] < t_a[2*k+1]))) begin
        t_f[k] = 1'b1;
        t_i[k] = t_i[2*k+2];
        t_a[k] = t_a[2*k+2];
      end else begin
        t_f[k] = t_f[2*k+1];
        t_i[k] = t_i[2*k+1];
        t_a[k] = t_a[2*k+1];
      end
    end
  end

  assign found = t_f[0];
  assign win = t_i[0];

  logic [4:0] wtag;
  logic [VW-1:0] wval;
  logic wake;
  logic do_wb;
  assign wtag = rob_q[win];
  assign wval = res_q[win];
  assign do_wb = ctrl_i.exec && (cmd_q == cdbwb_pkg::CmdWriteback) && found;
  assign wake = do_wb && (kind_q[win] == cdbwb_pkg::KindValue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= 5'd16;
      for (int i = 0; i < N; i++) begin
        status_q[i] <= cdbwb_pkg::StFree;
        wait_a_q[i] <= cdbwb_pkg::NullTag;
        wait_b_q[i] <= cdbwb_pkg::NullTag;
      end
    end else begin
      if (cfg_we_i) use_q <= cfg_wdata_i;
      if (ctrl_i.exec && cmd_q == cdbwb_pkg::CmdWrite) begin
        status_q[idx_q] <= (est_q == cdbwb_pkg::StInvalid) ? cdbwb_pkg::StFree : est_q;
        wait_a_q[idx_q] <= ewa_q;
        wait_b_q[idx_q] <= ewb_q;
      end
      if (do_wb) status_q[win] <= cdbwb_pkg::StFree;
      if (wake) begin
        for (int i = 0; i < N; i++) begin
          if (wait_a_q[i] == {1'b0, wtag}) wait_a_q[i] <= cdbwb_pkg::NullTag;
          if (wait_b_q[i] == {1'b0, wtag}) wait_b_q[i] <= cdbwb_pkg::NullTag;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && cmd_q == cdbwb_pkg::CmdWrite) begin
      age_q[idx_q] <= eage_q;
      res_q[idx_q] <= eres_q;
      rob_q[idx_q] <= erob_q;
      kind_q[idx_q] <= ekind_q;
      cond_q[idx_q] <= econd_q;
      opa_q[idx_q] <= eopa_q;
      opb_q[idx_q] <= eopb_q;
    end
    if (wake) begin
      for (int i = 0; i < N; i++) begin
        if (wait_a_q[i] == {1'b0, wtag}) opa_q[i] <= wval;
        if (wait_b_q[i] == {1'b0, wtag}) opb_q[i] <= wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      out_q <= '0;
      if (do_wb) begin
        out_q[0] <= 1'b1;
        out_q[5:1] <= wtag;
        out_q[69:6] <= wval;
        out_q[71:70] <= kind_q[win];
        out_q[72] <= cond_q[win];
      end
      if (cmd_q == cdbwb_pkg::CmdRead) begin
        out_q[74:73] <= status_q[idx_q];
        out_q[80:75] <= wait_a_q[idx_q];
        out_q[86:81] <= wait_b_q[idx_q];
        out_q[150:87] <= opa_q[idx_q];
        out_q[214:151] <= opb_q[idx_q];
      end
    end
  end

  assign out_data_o = out_q;
endmodule

// ----- hw/rtl/cdb_writeback_wakeup_core.sv -----
// Top level of the common data bus writeback and operand wakeup block.
// The slave stream carries one command per transaction: write a station,
// run a writeback, or read a station. Every command yields exactly one
// master transaction with the broadcast fields and the read fields.
// A command is registered on acceptance, executed in the next cycle against
// the station table (oldest finished search over up to 16 in-use stations plus tag
// wakeup), and its result is presented in the cycle after that.
// A new command is taken in the same cycle that the result is taken.
// While the receiver stalls, the result holds and no new command is taken.
// Reset frees all stations, sets all wait tags to the null tag, and sets
// the number of searched stations to 16. The configuration register is
// written whenever cfg_we_i is high and should change only while idle.
`timescale 1ns / 1ps
module cdb_writeback_wakeup_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command, station_index, entry_status, entry_age, entry_result,
  // entry_rob_tag, entry_kind, entry_condition, entry_wait_tag_a,
  // entry_wait_tag_b, entry_operand_a, entry_operand_b
  input  logic [239:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // broadcast_valid, broadcast_rob_tag, broadcast_value, broadcast_kind,
  // broadcast_condition, read_status, read_wait_tag_a, read_wait_tag_b,
  // read_operand_a, read_operand_b
  output logic [215:0] m_axis_tdata
);
  cdbwb_pkg::ctrl_t ctrl;

  cdbwb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .ctrl_o(ctrl)
  );

  cdbwb_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .cfg_wdata_i, .cfg_we_i,
    .in_data_i(s_axis_tdata[235:0]),
    .out_data_o(m_axis_tdata)
  );
endmodule
